// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker modules.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, skipped while rst is high.
`define MHT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("mht assertion failed");

// Check that cons holds in the same cycle whenever ante holds.
`define MHT_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   `MHT_ASSERT(name, clk, rst, (ante) |-> (cons))

`endif

// ----- hw/rtl/mht_pkg.sv -----
// Shared types and constants of the multiplicative hash table.
// No dependencies; imported by all modules of the block.
package mht_pkg;

   // floor(((sqrt(7) - 1) / 2) * 2^32), unsigned 0.32 fixed point
   localparam logic [31:0] HASH_A = 32'd3534224029;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_SEARCH = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_FOUND     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_INSERT,
      ST_SCAN
   } state_type;

endpackage

// ----- hw/rtl/mht_hash.sv -----
// Two-stage multiplicative hash: key * A (low 32 bits), then scale by bucket count.
// Depends on mht_pkg.
module mht_hash #(
   parameter int BUCKETS = 8
) (
   input  logic                       clock,
   input  logic                       load,
   input  logic [31:0]                key,
   output logic [$clog2(BUCKETS)-1:0] bucket
);
   import mht_pkg::*;

   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int CNT_W  = $clog2(BUCKETS + 1);
   localparam int PROD_W = 32 + CNT_W;

   logic [31:0]       key_prod;
   logic [31:0]       frac_ff;
   logic [PROD_W-1:0] scale_prod;

   // Low word of the product is the fractional part of key * A.
   assign key_prod = key * HASH_A;

   always_ff @(posedge clock) begin
      if (load) begin
         frac_ff <= key_prod;
      end
   end

   // Integer part of frac * BUCKETS; always below BUCKETS.
   assign scale_prod = PROD_W'(frac_ff) * PROD_W'(BUCKETS);
   assign bucket     = scale_prod[32 +: BKT_W];

endmodule

// ----- hw/rtl/multiplicative_hash_table.sv -----
// Top level of the multiplicative hash table with fixed-slot buckets.
// Depends on mht_pkg and mht_hash.
//
// Usage:
// - Request channel: drive req_mode (0 insert, 1 search) and req_key with start.
//   A transaction is taken at a rising edge with start high and busy low.
// - Response channel: rsp_valid pulses for one cycle with rsp_status, rsp_bucket
//   and rsp_match_key. Exactly one response per request, in request order.
//   The receiver cannot stall; the response is flagged valid only for that one cycle.
// - From accept to response strobe (no new request is taken in between): the
//   hash is a registered multiply, then the bucket is registered; an insert
//   then writes its slot, while a search reads the bucket's filled slots one
//   slot per cycle through the single port, stopping at the first hit or at
//   the fill, with the compare in the cycle after the read.
// - busy drops in the same cycle the response strobe shows, so the next
//   request may be taken while the previous response is on the ports.
// - Reset clears the bucket fill counts and the control state; the slot
//   memory is not cleared since only slots below a bucket's fill are read.
module multiplicative_hash_table #(
   parameter int BUCKETS          = 8,
   parameter int SLOTS_PER_BUCKET = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_mode,
   input  logic signed [31:0]          req_key,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [$clog2(BUCKETS)-1:0]  rsp_bucket,
   output logic signed [31:0]          rsp_match_key
);
   import mht_pkg::*;

   localparam int BKT_W   = $clog2(BUCKETS);
   localparam int FILL_W  = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int DEPTH   = BUCKETS * SLOTS_PER_BUCKET;
   localparam int ADDR_W  = $clog2(DEPTH);

   state_type         state_ff, state_in;
   logic              mode_ff;
   logic [31:0]       key_ff;
   logic [BKT_W-1:0]  hash_bucket;
   logic [BKT_W-1:0]  bucket_ff;
   logic [FILL_W-1:0] fill_ff [BUCKETS];
   logic [FILL_W-1:0] fill_cur;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [31:0]       slot_mem [DEPTH];
   logic [31:0]       rdata_ff;
   logic [ADDR_W-1:0] base_addr;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we, mem_re;
   logic              accept, hit, scan_done, room;
   logic              rsp_load;
   status_type        status_in;
   logic [31:0]       match_in;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [BKT_W-1:0]  rsp_bucket_ff;
   logic [31:0]       rsp_match_key_ff;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   mht_hash #(
      .BUCKETS(BUCKETS)
   ) u_hash (
      .clock (clock),
      .load  (accept),
      .key   (req_key),
      .bucket(hash_bucket)
   );

   // Capture the request payload on accept, and the hashed bucket in ST_HASH.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
      end
      if (state_ff == ST_HASH) begin
         bucket_ff <= hash_bucket;
      end
   end

   assign fill_cur  = fill_ff[bucket_ff];
   assign room      = (fill_cur < FILL_W'(SLOTS_PER_BUCKET));
   assign hit       = pend_ff && (rdata_ff == key_ff);
   assign scan_done = hit || (idx_ff == fill_cur);
   assign base_addr = ADDR_W'(bucket_ff) * ADDR_W'(SLOTS_PER_BUCKET);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_HASH;
         end
         ST_HASH: begin
            state_in = (mode_ff == MODE_SEARCH) ? ST_SCAN : ST_INSERT;
         end
         ST_INSERT: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath controls and response values.
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = base_addr + ADDR_W'(idx_ff);
      idx_in    = idx_ff;
      pend_in   = 1'b0;
      rsp_load  = 1'b0;
      status_in = STATUS_NOT_FOUND;
      match_in  = 32'd0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_HASH: begin
            idx_in = '0;
         end
         ST_INSERT: begin
            // Append at the fill position; drop the key when the bucket is full.
            mem_we    = room;
            mem_addr  = base_addr + ADDR_W'(fill_cur);
            rsp_load  = 1'b1;
            status_in = room ? STATUS_INSERTED : STATUS_FULL;
         end
         ST_SCAN: begin
            // Read the next slot while the previous one is compared.
            mem_re  = !scan_done;
            pend_in = !scan_done;
            if (!scan_done) idx_in = idx_ff + 1'b1;
            rsp_load  = scan_done;
            status_in = hit ? STATUS_FOUND : STATUS_NOT_FOUND;
            match_in  = hit ? key_ff : 32'd0;
         end
         default: begin
         end
      endcase
   end

   // Control state and bucket fill counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < BUCKETS; b++) begin
            fill_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_load;
         if (mem_we) begin
            fill_ff[bucket_ff] <= fill_cur + 1'b1;
         end
      end
   end

   // Slot memory: one port, registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_addr] <= key_ff;
      end
      if (mem_re) begin
         rdata_ff <= slot_mem[mem_addr];
      end
   end

   // Response register: load the result with its strobe and hold it until the next response.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff    <= status_in;
         rsp_bucket_ff    <= bucket_ff;
         rsp_match_key_ff <= match_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_bucket    = rsp_bucket_ff;
   assign rsp_match_key = rsp_match_key_ff;

endmodule

// ----- hw/rtl/mht_checker.sv -----
// Port-level checker for the multiplicative hash table, with its bind.
// Depends on mht_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mht_checker #(
   parameter int BUCKETS = 8
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [1:0]                 rsp_status,
   input logic [$clog2(BUCKETS)-1:0] rsp_bucket,
   input logic [31:0]                rsp_match_key
);
   import mht_pkg::*;

   logic found;

   assign found = (rsp_status == STATUS_FOUND);

   `MHT_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy)
   `MHT_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid)
   `MHT_ASSERT_IMPLIES(a_rsp_ends_busy, clock, reset, rsp_valid, !busy && $past(busy))
   `MHT_ASSERT_IMPLIES(a_match_zero, clock, reset, rsp_valid && !found, rsp_match_key == 32'd0)
   `MHT_ASSERT_IMPLIES(a_bucket_range, clock, reset, rsp_valid,
                       32'(rsp_bucket) < 32'(BUCKETS))

endmodule

bind multiplicative_hash_table mht_checker #(
   .BUCKETS(BUCKETS)
) u_mht_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_status   (rsp_status),
   .rsp_bucket   (rsp_bucket),
   .rsp_match_key(rsp_match_key)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for multiplicative_hash_table: directed and random
// insert/search transactions, each checked against a behavioral copy of the table.
// Depends on mht_pkg and the multiplicative_hash_table RTL.
module testbench;
   import mht_pkg::*;

   localparam int NUM_BUCKETS   = 8;
   localparam int SLOTS         = 4;
   localparam int BUCKET_W      = $clog2(NUM_BUCKETS);
   localparam int HALF_PERIOD   = 6;
   localparam int RANDOM_OPS    = 1700;
   localparam int QUIET_TAIL    = 300;   // last transactions go back to back
   localparam int MAX_REPORTS   = 10;
   localparam int SETTLE_CYCLES = 20;    // longer than the slowest response
   localparam int DRAIN_LIMIT   = 1000;
   localparam longint RUN_LIMIT_NS = 3_000_000;

   // One queued transaction and one predicted response.
   typedef struct {
      mode_type    mode;
      logic [31:0] key;
      int unsigned gap;     // idle cycles before it is offered
      bit          drain;   // hold it back until every response has come
   } table_op_type;

   typedef struct {
      status_type          status;
      logic [BUCKET_W-1:0] bucket;
      logic [31:0]         match_key;
   } table_rsp_type;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       start     = 1'b0;
   logic                       req_mode  = MODE_INSERT;
   logic signed [31:0]         req_key   = '0;
   logic                       busy;
   logic                       rsp_valid;
   logic [1:0]                 rsp_status;
   logic [BUCKET_W-1:0]        rsp_bucket;
   logic signed [31:0]         rsp_match_key;

   table_op_type  pending_ops[$];     // transactions still to be sent
   table_rsp_type expected_rsps[$];   // responses owed by the block, oldest first
   logic [31:0]   inserted_keys[$];   // every key queued for insert, for searches

   // Behavioral copy of the table, updated as each transaction is accepted.
   logic [31:0] table_keys [NUM_BUCKETS][SLOTS];
   int unsigned table_fill [NUM_BUCKETS] = '{default: 0};

   int unsigned total_ops    = 0;
   int unsigned ops_accepted = 0;
   int unsigned error_count  = 0;

   table_op_type next_op;
   bit           op_loaded = 1'b0;
   int unsigned  gap_left  = 0;
   logic         req_taken = 1'b0;

   multiplicative_hash_table #(
      .BUCKETS          (NUM_BUCKETS),
      .SLOTS_PER_BUCKET (SLOTS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_bucket    (rsp_bucket),
      .rsp_match_key (rsp_match_key)
   );

   // Knuth hash: the low 32 bits of key * A are the fraction of key*A, and
   // scaling that fraction by the bucket count gives the bucket in the top bits.
   function automatic logic [BUCKET_W-1:0] bucket_of(logic [31:0] key);
      logic [63:0] product;
      logic [63:0] scaled;
      product = {32'd0, key} * {32'd0, HASH_A};
      scaled  = {32'd0, product[31:0]} * 64'(NUM_BUCKETS);
      return scaled[32 +: BUCKET_W];
   endfunction

   // Apply one transaction to the table copy and return the response it owes.
   function automatic table_rsp_type apply_table_op(mode_type mode, logic [31:0] key);
      table_rsp_type       rsp;
      logic [BUCKET_W-1:0] b;
      b             = bucket_of(key);
      rsp.bucket    = b;
      rsp.match_key = '0;
      if (mode == MODE_INSERT) begin
         // A full bucket leaves the table untouched.
         if (table_fill[b] < SLOTS) begin
            table_keys[b][table_fill[b]] = key;
            table_fill[b]++;
            rsp.status = STATUS_INSERTED;
         end else begin
            rsp.status = STATUS_FULL;
         end
      end else begin
         // Scan only the filled slots; the first match wins, and a miss
         // (empty bucket included) returns a zero key.
         rsp.status = STATUS_NOT_FOUND;
         for (int i = 0; i < int'(table_fill[b]); i++) begin
            if (rsp.status == STATUS_NOT_FOUND && table_keys[b][i] == key) begin
               rsp.status    = STATUS_FOUND;
               rsp.match_key = key;
            end
         end
      end
      return rsp;
   endfunction

   function automatic void report_failure(string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch at %0t ns: %s", $realtime, what);
   endfunction

   // Mostly full-range keys, now and then one of the extremes.
   function automatic logic [31:0] random_key();
      case ($urandom_range(19))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0000;
         default: return $urandom();
      endcase
   endfunction

   // Draw keys until one lands in bucket b (about eight draws on average).
   function automatic logic [31:0] key_in_bucket(logic [BUCKET_W-1:0] b);
      logic [31:0] key;
      key = $urandom();
      while (bucket_of(key) != b)
         key = $urandom();
      return key;
   endfunction

   function automatic void queue_op(mode_type mode, logic [31:0] key, int unsigned gap,
                                    bit drain);
      table_op_type op;
      op.mode  = mode;
      op.key   = key;
      op.gap   = gap;
      op.drain = drain;
      pending_ops.push_back(op);
      if (mode == MODE_INSERT)
         inserted_keys.push_back(key);
   endfunction

   initial begin
      forever #(HALF_PERIOD) clock = ~clock;
   end

   // Driver: change inputs on the falling edge. Hold a transaction on the
   // port until the rising edge that takes it, then either offer the next
   // one in the same step or drop start for an idle burst or a drain.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (!op_loaded && pending_ops.size() != 0) begin
            next_op   = pending_ops.pop_front();
            gap_left  = next_op.gap;
            op_loaded = 1'b1;
         end
         if (op_loaded && gap_left == 0 &&
             (!next_op.drain || (expected_rsps.size() == 0 && !busy))) begin
            start     <= 1'b1;
            req_mode  <= next_op.mode;
            req_key   <= next_op.key;
            op_loaded = 1'b0;
         end else begin
            if (gap_left != 0)
               gap_left--;
            start <= 1'b0;
         end
      end
   end

   // Monitor: sample both channels on the rising edge. Check the response
   // first, since busy drops in the cycle the strobe shows and a new
   // transaction may be taken at the same edge.
   always @(posedge clock) begin
      table_rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid !== 1'b0) begin
            if (expected_rsps.size() == 0) begin
               report_failure($sformatf(
                  "response with none outstanding: status %0d bucket %0d key %h",
                  rsp_status, rsp_bucket, rsp_match_key));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status || rsp_bucket !== want.bucket ||
                   rsp_match_key !== want.match_key)
                  report_failure($sformatf(
                     "expected status %0d bucket %0d key %h, got status %0d bucket %0d key %h",
                     want.status, want.bucket, want.match_key,
                     rsp_status, rsp_bucket, rsp_match_key));
            end
         end
         req_taken <= start && !busy;
         if (start && !busy) begin
            expected_rsps.push_back(apply_table_op(mode_type'(req_mode), req_key));
            ops_accepted <= ops_accepted + 1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [31:0]         extreme_keys [5];
      logic [31:0]         fill_keys [4];
      bit                  bucket_used [NUM_BUCKETS];
      logic [BUCKET_W-1:0] spare_bucket;
      int unsigned         gap;
      bit                  drain;
      int unsigned         pick;
      int unsigned         waited;

      extreme_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h0000_0001};
      bucket_used  = '{default: 1'b0};

      // Search before anything is stored: empty bucket, not found.
      queue_op(MODE_SEARCH, extreme_keys[0], 0, 1'b0);
      foreach (extreme_keys[i]) begin
         queue_op(MODE_INSERT, extreme_keys[i], 0, 1'b0);
         bucket_used[bucket_of(extreme_keys[i])] = 1'b1;
      end
      // Wait for the table to go idle once, then hit the stored extremes.
      queue_op(MODE_SEARCH, extreme_keys[0], 0, 1'b1);
      queue_op(MODE_SEARCH, extreme_keys[3], 0, 1'b0);
      queue_op(MODE_SEARCH, extreme_keys[1], 0, 1'b0);

      // Fill an untouched bucket with a duplicate, overflow it, then search
      // the deepest slot, a middle slot, the duplicate and a miss in it.
      spare_bucket = '0;
      for (int b = NUM_BUCKETS - 1; b >= 0; b--)
         if (!bucket_used[b])
            spare_bucket = BUCKET_W'(b);
      foreach (fill_keys[i])
         fill_keys[i] = key_in_bucket(spare_bucket);
      queue_op(MODE_INSERT, fill_keys[0], 0, 1'b0);
      queue_op(MODE_INSERT, fill_keys[0], 0, 1'b0);
      queue_op(MODE_INSERT, fill_keys[1], 0, 1'b0);
      queue_op(MODE_INSERT, fill_keys[2], 0, 1'b0);
      queue_op(MODE_INSERT, fill_keys[3], 0, 1'b0);
      queue_op(MODE_SEARCH, fill_keys[2], 0, 1'b0);
      queue_op(MODE_SEARCH, fill_keys[1], 0, 1'b0);
      queue_op(MODE_SEARCH, fill_keys[0], 0, 1'b0);
      queue_op(MODE_SEARCH, fill_keys[3], 0, 1'b0);

      // Random part: searches favor stored keys so hits reach every slot,
      // and misses land in occupied buckets to run the full scan.
      for (int n = 0; n < RANDOM_OPS; n++) begin
         gap   = 0;
         drain = 1'b0;
         if (n < RANDOM_OPS - QUIET_TAIL) begin
            if ($urandom_range(9) < 3)
               gap = $urandom_range(10, 1);
            drain = ($urandom_range(99) == 0);
         end
         pick = $urandom_range(99);
         if (pick < 30)
            queue_op(MODE_INSERT, random_key(), gap, drain);
         else if (pick < 38)
            queue_op(MODE_INSERT, inserted_keys[$urandom_range(inserted_keys.size() - 1)],
                     gap, drain);
         else if (pick < 75)
            queue_op(MODE_SEARCH, inserted_keys[$urandom_range(inserted_keys.size() - 1)],
                     gap, drain);
         else if (pick < 88)
            queue_op(MODE_SEARCH, key_in_bucket(bucket_of(
                        inserted_keys[$urandom_range(inserted_keys.size() - 1)])), gap, drain);
         else
            queue_op(MODE_SEARCH, random_key(), gap, drain);
      end
      total_ops = pending_ops.size();

      // Hold reset from the start of the run, release it on a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Advance until every transaction is taken, then until every response
      // is back, then a little longer to catch stray strobes.
      while (ops_accepted != total_ops)
         @(negedge clock);
      for (waited = 0; waited < DRAIN_LIMIT && expected_rsps.size() != 0; waited++)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_rsps.size() != 0)
         report_failure($sformatf("%0d responses never arrived", expected_rsps.size()));

      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   // Stop a hung run.
   initial begin
      #(RUN_LIMIT_NS);
      $display("testbench: done, errors");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/mht_pkg.sv
hw/rtl/mht_hash.sv
hw/rtl/multiplicative_hash_table.sv
hw/rtl/mht_checker.sv
test/testbench.sv
